// ===== hw/rtl/rgbhsl_pkg.sv =====
// rgbhsl_pkg: shared constants and types for the RGB to HSL converter.
// No dependencies; every other file of the block imports it.
`default_nettype none

package rgbhsl_pkg;

  localparam int CHAN_W      = 8;    // input channel width
  localparam int FRAC_W      = 16;   // output fraction width, units of 1/65536
  localparam int SUM_W       = 9;    // max + min
  localparam int H6_W        = 11;   // sextant position and 6*delta, below 1536
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [SUM_W-1:0] CHAN_MAX   = 9'd255;
  localparam logic [SUM_W-1:0] TWICE_MAX  = 9'd510;

  // floor(y/255) == (y * ceil(2^24/255)) >> 24 for every y below 2^16
  localparam logic [16:0] LIGHT_RECIP = 17'd65794;
  localparam int          LIGHT_SHIFT = 24;

  // start accepted -> front reg -> queue -> divider input -> FRAC_W steps -> output reg
  localparam int LATENCY = FRAC_W + 4;

  typedef enum logic [2:0] {
    SEL_RED   = 3'b001,
    SEL_GREEN = 3'b010,
    SEL_BLUE  = 3'b100
  } chan_sel_t;

  typedef struct packed {
    logic              gray;
    logic [SUM_W-1:0]  sum;
    logic [CHAN_W-1:0] delta;
    logic [CHAN_W-1:0] sat_den;
    logic [H6_W-1:0]   h6;
    logic [H6_W-1:0]   hue_den;
  } item_t;

  typedef struct packed {
    logic              gray;
    logic              sat_full;
    logic [FRAC_W-1:0] lightness;
  } side_t;

endpackage

`default_nettype wire

// ===== hw/rtl/rgbhsl_front.sv =====
// rgbhsl_front: takes a pixel, finds max/min and the largest channel, and
// prepares numerators and divisors for the back end. Uses rgbhsl_pkg.
`default_nettype none

module rgbhsl_front (
  input  wire                        clk,
  input  wire                        rst,
  input  wire                        take,
  input  wire [rgbhsl_pkg::CHAN_W-1:0] red,
  input  wire [rgbhsl_pkg::CHAN_W-1:0] green,
  input  wire [rgbhsl_pkg::CHAN_W-1:0] blue,
  output logic                       item_vld,
  output rgbhsl_pkg::item_t          item
);
  import rgbhsl_pkg::*;

  chan_sel_t         sel;
  logic [CHAN_W-1:0] mx, mn, delta;
  logic [SUM_W-1:0]  sum, sat_den9;
  logic [H6_W-1:0]   r_x, g_x, b_x, d_x, h6;
  item_t             item_next;

  always_comb begin
    // ties go to red first, then green
    if (red >= green && red >= blue) begin
      sel = SEL_RED;
    end else if (green >= blue) begin
      sel = SEL_GREEN;
    end else begin
      sel = SEL_BLUE;
    end
    case (sel)
      SEL_RED:   mx = red;
      SEL_GREEN: mx = green;
      default:   mx = blue;
    endcase
    mn = red;
    if (green < mn) mn = green;
    if (blue < mn) mn = blue;
  end

  assign delta    = mx - mn;
  assign sum      = {1'b0, mx} + {1'b0, mn};
  assign sat_den9 = (sum > CHAN_MAX) ? (TWICE_MAX - sum) : sum;

  assign r_x = {3'b000, red};
  assign g_x = {3'b000, green};
  assign b_x = {3'b000, blue};
  assign d_x = {3'b000, delta};

  // modular arithmetic at H6_W bits: every result with a nonzero delta lands below 6*delta
  always_comb begin
    case (sel)
      SEL_RED: begin
        if (green >= blue) begin
          h6 = g_x - b_x;
        end else begin
          h6 = (d_x << 2) + (d_x << 1) - (b_x - g_x);
        end
      end
      SEL_GREEN: h6 = (d_x << 1) + b_x - r_x;
      default:   h6 = (d_x << 2) + r_x - g_x;
    endcase
  end

  always_comb begin
    item_next.gray    = (delta == '0);
    item_next.sum     = sum;
    item_next.delta   = delta;
    item_next.sat_den = sat_den9[CHAN_W-1:0];
    item_next.h6      = h6;
    item_next.hue_den = (d_x << 2) + (d_x << 1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      item_vld <= 1'b0;
    end else begin
      item_vld <= take;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      item <= item_next;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/rgbhsl_queue.sv =====
// rgbhsl_queue: short FIFO between the front and the back end.
// Uses rgbhsl_pkg (item_t, QUEUE_DEPTH).
`default_nettype none

module rgbhsl_queue (
  input  wire                clk,
  input  wire                rst,
  input  wire                push,
  input  rgbhsl_pkg::item_t  push_item,
  output logic               pop_vld,
  output rgbhsl_pkg::item_t  pop_item,
  output logic               busy
);
  import rgbhsl_pkg::*;

  item_t             mem [0:QUEUE_DEPTH-1];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [QCNT_W-1:0] cnt;

  // the back end never stalls, so an occupied head is popped every cycle
  assign pop_vld  = (cnt != '0);
  assign pop_item = mem[rd_ptr];
  // the head leaves every cycle, so the front only has to wait on a full queue
  assign busy = (cnt == QCNT_W'(QUEUE_DEPTH));

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      cnt    <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop_vld) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      cnt <= cnt + QCNT_W'(push) - QCNT_W'(pop_vld);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/rgbhsl_div.sv =====
// rgbhsl_div: pipelined restoring divider, one quotient bit per stage.
// Gives floor(num * 2^FRAC_W / den) for num < den. Uses rgbhsl_pkg.
`default_nettype none

module rgbhsl_div #(
  parameter int DEN_W = 8
) (
  input  wire                          clk,
  input  wire  [DEN_W-1:0]             num,
  input  wire  [DEN_W-1:0]             den,
  output logic [rgbhsl_pkg::FRAC_W-1:0] quo
);
  import rgbhsl_pkg::*;

  logic [DEN_W-1:0]  rem_q [0:FRAC_W];
  logic [DEN_W-1:0]  den_q [0:FRAC_W];
  logic [FRAC_W-1:0] quo_q [1:FRAC_W];

  always_ff @(posedge clk) begin
    rem_q[0] <= num;
    den_q[0] <= den;
  end

  for (genvar k = 1; k <= FRAC_W; k++) begin : g_step
    logic [DEN_W:0]    trial;
    logic              fits;
    logic [FRAC_W-1:0] prev;

    assign trial = {rem_q[k-1], 1'b0};
    assign fits  = (trial >= {1'b0, den_q[k-1]});

    if (k == 1) begin : g_first
      assign prev = '0;
    end else begin : g_rest
      assign prev = quo_q[k-1];
    end

    always_ff @(posedge clk) begin
      rem_q[k] <= fits ? DEN_W'(trial - {1'b0, den_q[k-1]}) : trial[DEN_W-1:0];
      den_q[k] <= den_q[k-1];
      quo_q[k] <= {prev[FRAC_W-2:0], fits};
    end
  end

  assign quo = quo_q[FRAC_W];

endmodule

`default_nettype wire

// ===== hw/rtl/rgbhsl_back.sv =====
// rgbhsl_back: divides for hue and saturation, scales lightness, and drives
// the result strobe. Uses rgbhsl_pkg and rgbhsl_div.
`default_nettype none

module rgbhsl_back (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          item_vld,
  input  rgbhsl_pkg::item_t            item,
  output logic                         strobe,
  output logic [rgbhsl_pkg::FRAC_W-1:0] hue,
  output logic [rgbhsl_pkg::FRAC_W-1:0] saturation,
  output logic [rgbhsl_pkg::FRAC_W-1:0] lightness
);
  import rgbhsl_pkg::*;

  logic [FRAC_W-1:0] light_base;
  logic [32:0]       light_prod;
  logic [SUM_W-1:0]  light_frac;
  logic [FRAC_W:0]   light_sum;
  side_t             side_next;
  side_t             sb [0:FRAC_W];
  logic              sb_vld [0:FRAC_W];
  logic [FRAC_W-1:0] hue_quo, sat_quo;

  // sum*65536/510 = sum*128 + floor(sum*128/255)
  assign light_base = {item.sum, 7'b0};
  assign light_prod = {17'b0, light_base} * {16'b0, LIGHT_RECIP};
  assign light_frac = light_prod[LIGHT_SHIFT +: SUM_W];
  assign light_sum  = {1'b0, light_base} + {8'b0, light_frac};

  always_comb begin
    side_next.gray      = item.gray;
    side_next.sat_full  = ({1'b0, item.delta} == {1'b0, item.sat_den});
    side_next.lightness = light_sum[FRAC_W] ? '1 : light_sum[FRAC_W-1:0];
  end

  rgbhsl_div #(.DEN_W(CHAN_W)) u_sat_div (
    .clk (clk),
    .num (item.delta),
    .den (item.sat_den),
    .quo (sat_quo)
  );

  rgbhsl_div #(.DEN_W(H6_W)) u_hue_div (
    .clk (clk),
    .num (item.h6),
    .den (item.hue_den),
    .quo (hue_quo)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k <= FRAC_W; k++) sb_vld[k] <= 1'b0;
      strobe <= 1'b0;
    end else begin
      sb_vld[0] <= item_vld;
      for (int k = 1; k <= FRAC_W; k++) sb_vld[k] <= sb_vld[k-1];
      strobe <= sb_vld[FRAC_W];
    end
  end

  always_ff @(posedge clk) begin
    sb[0] <= side_next;
    for (int k = 1; k <= FRAC_W; k++) sb[k] <= sb[k-1];
  end

  // gray pixels have no hue and no saturation; d equal to the divisor is 1.0
  always_ff @(posedge clk) begin
    hue        <= sb[FRAC_W].gray ? '0 : hue_quo;
    saturation <= sb[FRAC_W].gray ? '0 : (sb[FRAC_W].sat_full ? '1 : sat_quo);
    lightness  <= sb[FRAC_W].lightness;
  end

endmodule

`default_nettype wire

// ===== hw/rtl/rgb_to_hsl_converter.sv =====
// rgb_to_hsl_converter: top level, RGB pixel in, HSL fractions out.
// Uses rgbhsl_pkg, rgbhsl_front, rgbhsl_queue, rgbhsl_back.
//
//   channel  | handshake         | payload
//   ---------+-------------------+-------------------------------
//   pixel in | start / busy      | red, green, blue (8 b each)
//   result   | strobe (1 cycle)  | hue, saturation, lightness (16 b)
//
// One pixel per clock while busy is low; strobe follows an accepted start
// through the front reg, the queue, the 16-step divider pipelines and the output regs.
// busy is high during reset and otherwise only if the queue fills up.
// Reset clears all valid flags; nothing else needs clearing.
// Results cannot be held off: each stays on the ports for one cycle.
`default_nettype none

module rgb_to_hsl_converter (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          start,
  output logic                         busy,
  input  wire  [rgbhsl_pkg::CHAN_W-1:0] red,
  input  wire  [rgbhsl_pkg::CHAN_W-1:0] green,
  input  wire  [rgbhsl_pkg::CHAN_W-1:0] blue,
  output logic                         strobe,
  output logic [rgbhsl_pkg::FRAC_W-1:0] hue,
  output logic [rgbhsl_pkg::FRAC_W-1:0] saturation,
  output logic [rgbhsl_pkg::FRAC_W-1:0] lightness
);
  import rgbhsl_pkg::*;

  logic  take;
  logic  front_vld, q_vld, q_busy;
  item_t front_item, q_item;

  assign busy = q_busy | rst;
  assign take = start & ~busy;

  rgbhsl_front u_front (
    .clk      (clk),
    .rst      (rst),
    .take     (take),
    .red      (red),
    .green    (green),
    .blue     (blue),
    .item_vld (front_vld),
    .item     (front_item)
  );

  rgbhsl_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (front_vld),
    .push_item (front_item),
    .pop_vld   (q_vld),
    .pop_item  (q_item),
    .busy      (q_busy)
  );

  rgbhsl_back u_back (
    .clk        (clk),
    .rst        (rst),
    .item_vld   (q_vld),
    .item       (q_item),
    .strobe     (strobe),
    .hue        (hue),
    .saturation (saturation),
    .lightness  (lightness)
  );

endmodule

`default_nettype wire

// ===== hw/rtl/rgbhsl_checker.sv =====
// rgbhsl_checker: port-level assertions for rgb_to_hsl_converter, bound
// to the top level below. Uses rgbhsl_pkg.
`default_nettype none

module rgbhsl_checker (
  input wire                          clk,
  input wire                          rst,
  input wire                          start,
  input wire                          busy,
  input wire [rgbhsl_pkg::CHAN_W-1:0] red,
  input wire [rgbhsl_pkg::CHAN_W-1:0] green,
  input wire [rgbhsl_pkg::CHAN_W-1:0] blue,
  input wire                          strobe,
  input wire [rgbhsl_pkg::FRAC_W-1:0] hue,
  input wire [rgbhsl_pkg::FRAC_W-1:0] saturation,
  input wire [rgbhsl_pkg::FRAC_W-1:0] lightness
);
  import rgbhsl_pkg::*;

  // every transfer in gives exactly one result, a fixed time later
  a_latency_hit: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##LATENCY strobe)
    else $error("missing result strobe");

  a_latency_miss: assert property (@(posedge clk) disable iff (rst)
    !(start && !busy) |-> ##LATENCY !strobe)
    else $error("result strobe without a transfer");

  a_gray: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && red == green && green == blue)
      |-> ##LATENCY (hue == '0 && saturation == '0))
    else $error("gray pixel with nonzero hue or saturation");

  a_white: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && red == '1 && green == '1 && blue == '1)
      |-> ##LATENCY (lightness == '1))
    else $error("white pixel lightness not saturated");

endmodule

bind rgb_to_hsl_converter rgbhsl_checker u_rgbhsl_checker (.*);

`default_nettype wire
